// ----- hw/rtl/conv3x3_rgb_filter_defines.svh -----
// ----------------------------------------------------------------------------
// conv3x3_rgb_filter_defines
// Assertion macros shared by the filter RTL. Each expects clk_i and rst_ni
// in scope.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_RGB_FILTER_DEFINES_SVH
`define CONV3X3_RGB_FILTER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define C3RGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define C3RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/c3rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// c3rgb_pkg
// Types, register codes and kernel arithmetic for the 3x3 RGB filter.
// ----------------------------------------------------------------------------
package c3rgb_pkg;

  // Geometry defaults
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Register port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned IMG_W_W    = 12;
  localparam int unsigned IMG_H_W    = 13;

  localparam logic [IMG_W_W-1:0] RST_WIDTH  = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] RST_HEIGHT = IMG_H_W'(480);

  // Kernel sum width: covers -1020 .. 4080
  localparam int unsigned SUM_W = 13;

  // Division by three as multiply by reciprocal, exact for sums up to 1275
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_BLUR    = 3'd0,
    MODE_SHARPEN = 3'd1,
    MODE_EDGE    = 3'd2,
    MODE_EMBOSS  = 3'd3,
    MODE_MAGIC   = 3'd4,
    MODE_NONE    = 3'd5
  } mode_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       is_padding;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_of_frame;
  } pix_out_t;

  // Per-word tap qualifiers, worked out from the item count on entry
  typedef struct packed {
    logic ok_bot;   // newest word lies inside the frame
    logic ok_mid;   // word one row back lies inside the frame
    logic ok_top;   // word two rows back lies inside the frame
    logic z1;       // first word of frame: one-back taps are stale
    logic z2;       // first two words: two-back taps are stale
    logic has_res;  // this word completes a window
    logic last;     // window of the final pixel
  } tap_ctl_t;

  typedef logic signed [SUM_W-1:0] acc_t;
  typedef logic [8:0][7:0] taps_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    acc_t              sum_r;
    acc_t              sum_g;
    acc_t              sum_b;
    logic              has_res;
    logic              last;
  } ksum_t;

  // Weighted 3x3 sum for one channel; taps 0..8 in raster order
  function automatic acc_t kernel_sum(logic [MODE_W-1:0] mode, taps_t t);
    acc_t x [9];
    acc_t s;
    for (int k = 0; k < 9; k++) begin
      x[k] = acc_t'({5'd0, t[k]});
    end
    unique case (mode)
      MODE_BLUR: begin
        s = x[0] + (x[1] <<< 1) + x[2] + (x[3] <<< 1) + (x[4] <<< 2)
          + (x[5] <<< 1) + x[6] + (x[7] <<< 1) + x[8];
      end
      MODE_SHARPEN: s = (x[4] <<< 2) + x[4] - x[1] - x[3] - x[5] - x[7];
      MODE_EDGE:    s = x[0] - x[2] + x[6] - x[8];
      MODE_EMBOSS:  s = x[4] + x[5] + x[7] + (x[8] <<< 1) - (x[0] <<< 1) - x[1] - x[3];
      MODE_MAGIC:   s = x[2] + x[4] + x[8];
      default:      s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] sat8(acc_t s);
    logic [7:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s > acc_t'(255)) begin
      r = 8'hFF;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

  // Scaling and clamping of a kernel sum
  function automatic logic [7:0] finish(logic [MODE_W-1:0] mode, acc_t s);
    logic [20:0] prod;
    logic [7:0]  r;
    prod = 21'(s[10:0]) * 21'(DIV3_MUL);
    unique case (mode)
      MODE_BLUR: r = s[11:4];
      MODE_SHARPEN: begin
        if (s < 0) begin
          r = '0;
        end else begin
          r = sat8(acc_t'({3'd0, prod[20:DIV3_SHIFT]}));
        end
      end
      MODE_EDGE, MODE_EMBOSS, MODE_MAGIC: r = sat8(s);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/c3rgb_ram.sv -----
// ----------------------------------------------------------------------------
// c3rgb_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module c3rgb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // same-address read returns the old word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/c3rgb_window.sv -----
// ----------------------------------------------------------------------------
// c3rgb_window
// 3x3 tap registers fed by the three row words, edge masking and the
// kernel sum stage.
// ----------------------------------------------------------------------------
module c3rgb_window import c3rgb_pkg::*; (
  input  logic              clk_i,
  input  logic              shift_i,
  input  tap_ctl_t          ctl_i,
  input  rgb_t              bot_i,
  input  rgb_t              mid_i,
  input  rgb_t              top_i,
  input  logic [MODE_W-1:0] mode_i,
  output ksum_t             sum_o
);

  rgb_t  bot1_q, bot2_q, mid1_q, mid2_q, top1_q, top2_q;
  rgb_t  bot_m, mid_m, top_m;
  rgb_t  tap [9];
  taps_t tr, tg, tb;
  ksum_t sum_q;

  // mask out-of-frame words and stale taps from the previous frame
  always_comb begin
    bot_m  = ctl_i.ok_bot ? bot_i : '0;
    mid_m  = ctl_i.ok_mid ? mid_i : '0;
    top_m  = ctl_i.ok_top ? top_i : '0;
    tap[0] = ctl_i.z2 ? '0 : top2_q;
    tap[1] = ctl_i.z1 ? '0 : top1_q;
    tap[2] = top_m;
    tap[3] = ctl_i.z2 ? '0 : mid2_q;
    tap[4] = ctl_i.z1 ? '0 : mid1_q;
    tap[5] = mid_m;
    tap[6] = ctl_i.z2 ? '0 : bot2_q;
    tap[7] = ctl_i.z1 ? '0 : bot1_q;
    tap[8] = bot_m;
    for (int k = 0; k < 9; k++) begin
      tr[k] = tap[k].red;
      tg[k] = tap[k].green;
      tb[k] = tap[k].blue;
    end
  end

  // shift taps and register the weighted sums
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      bot1_q        <= bot_m;
      bot2_q        <= bot1_q;
      mid1_q        <= mid_m;
      mid2_q        <= mid1_q;
      top1_q        <= top_m;
      top2_q        <= top1_q;
      sum_q.mode    <= mode_i;
      sum_q.sum_r   <= kernel_sum(mode_i, tr);
      sum_q.sum_g   <= kernel_sum(mode_i, tg);
      sum_q.sum_b   <= kernel_sum(mode_i, tb);
      sum_q.has_res <= ctl_i.has_res;
      sum_q.last    <= ctl_i.last;
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- hw/rtl/c3rgb_post.sv -----
// ----------------------------------------------------------------------------
// c3rgb_post
// Divide and clamp stage with the output word register.
// ----------------------------------------------------------------------------
module c3rgb_post import c3rgb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  ksum_t    sum_i,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output pix_out_t out_data_o,
  output logic     ready_o
);

  logic     out_valid_q;
  pix_out_t out_data_q;

  // free when empty or when the held word leaves this cycle
  assign ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_data_q.red_out       <= finish(sum_i.mode, sum_i.sum_r);
      out_data_q.green_out     <= finish(sum_i.mode, sum_i.sum_g);
      out_data_q.blue_out      <= finish(sum_i.mode, sum_i.sum_b);
      out_data_q.last_of_frame <= sum_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hw/rtl/conv3x3_rgb_filter.sv -----
// ----------------------------------------------------------------------------
// conv3x3_rgb_filter
// Streaming 3x3 kernel filter over RGB pixels in raster order, with two
// row-delay RAMs feeding a tap window.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------
//   in      | input     | in_valid_i / in_stall_o  | in_data_i
//   out     | output    | out_valid_o / out_stall_i| out_data_o
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while in_stall_o is low; a result follows its
// completing word through the two RAM read stages, the sum stage and the
// output register. No clearing pass: out-of-frame taps are masked by index.
// After reset and after a width or height write the input stalls
// while frame limits are recomputed. Output stall backs up through bubble-
// collapsing stages, so words still enter while the pipeline has room.
// ----------------------------------------------------------------------------
`include "conv3x3_rgb_filter_defines.svh"

module conv3x3_rgb_filter import c3rgb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);

  // Configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic               cfg_wait_q;
  logic               geo_wr;

  assign geo_wr = cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_BLUR;
      width_q    <= RST_WIDTH;
      height_q   <= RST_HEIGHT;
      cfg_wait_q <= 1'b1;
    end else begin
      cfg_wait_q <= geo_wr;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
          CFG_WIDTH:  width_q  <= cfg_data_i[IMG_W_W-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[IMG_H_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Frame limits, clamped and registered
  logic [WW-1:0] w_eff_d;
  logic [HW-1:0] h_eff_d;
  logic [CW-1:0] w_ext, h_ext;
  logic [CW-1:0] wc_q, w1_q, w2_q, size_q, size_w_q;
  logic [AW-1:0] wm1_q;

  always_comb begin
    if (width_q == '0) begin
      w_eff_d = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff_d = WW'(MAX_WIDTH);
    end else begin
      w_eff_d = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff_d = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff_d = HW'(MAX_HEIGHT);
    end else begin
      h_eff_d = HW'(height_q);
    end
    w_ext = CW'(w_eff_d);
    h_ext = CW'(h_eff_d);
  end

  always_ff @(posedge clk_i) begin
    wc_q     <= w_ext;
    w1_q     <= w_ext + CW'(1);
    w2_q     <= w_ext << 1;
    wm1_q    <= AW'(w_eff_d - WW'(1));
    size_q   <= w_ext * h_ext;
    size_w_q <= w_ext * (h_ext + CW'(1));
  end

  // Pipeline handshake
  logic     v1_q, v2_q, v3_q;
  logic     acc, mv1, mv2, mv3;
  logic     post_ready;
  ksum_t    sum;

  assign mv3        = v3_q && (!sum.has_res || post_ready);
  assign mv2        = v2_q && (!v3_q || mv3);
  assign mv1        = v1_q && (!v2_q || mv2);
  assign in_stall_o = cfg_wait_q || (v1_q && !mv1);
  assign acc        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (acc) begin
        v1_q <= 1'b1;
      end else if (mv1) begin
        v1_q <= 1'b0;
      end
      if (mv1) begin
        v2_q <= 1'b1;
      end else if (mv2) begin
        v2_q <= 1'b0;
      end
      if (mv2) begin
        v3_q <= 1'b1;
      end else if (mv3) begin
        v3_q <= 1'b0;
      end
    end
  end

  // Item count and row address
  logic [CW-1:0] n_q;
  logic [AW-1:0] a_q;
  tap_ctl_t      s0_ctl;
  rgb_t          pix0;

  always_comb begin
    s0_ctl.ok_bot  = n_q < size_q;
    s0_ctl.ok_mid  = (n_q >= wc_q) && (n_q < size_w_q);
    s0_ctl.ok_top  = n_q >= w2_q;
    s0_ctl.z1      = n_q == '0;
    s0_ctl.z2      = n_q[CW-1:1] == '0;
    s0_ctl.has_res = n_q >= w1_q;
    s0_ctl.last    = n_q >= size_w_q;
    pix0.red       = in_data_i.is_padding ? '0 : in_data_i.red_in;
    pix0.green     = in_data_i.is_padding ? '0 : in_data_i.green_in;
    pix0.blue      = in_data_i.is_padding ? '0 : in_data_i.blue_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      a_q <= '0;
    end else if (geo_wr) begin
      n_q <= '0;
      a_q <= '0;
    end else if (acc) begin
      if (s0_ctl.last) begin
        n_q <= '0;
        a_q <= '0;
      end else begin
        n_q <= n_q + CW'(1);
        a_q <= (a_q == wm1_q) ? '0 : a_q + AW'(1);
      end
    end
  end

  // Stage payloads
  rgb_t     s1_pix_q, s2_bot_q, s2_mid_q;
  tap_ctl_t s1_ctl_q, s2_ctl_q;
  logic [AW-1:0] s1_addr_q;
  rgb_t     ram_a_rdata, ram_b_rdata;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= pix0;
      s1_ctl_q  <= s0_ctl;
      s1_addr_q <= a_q;
    end
    if (mv1) begin
      s2_bot_q <= s1_pix_q;
      s2_mid_q <= ram_a_rdata;
      s2_ctl_q <= s1_ctl_q;
    end
  end

  // Row delay one: newest word in, word one row back out
  c3rgb_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (MAX_WIDTH)
  ) u_row_a (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (a_q),
    .wdata_i (pix0),
    .re_i    (acc),
    .raddr_i (a_q),
    .rdata_o (ram_a_rdata)
  );

  // Row delay two: one-row-back word in, two-rows-back word out
  c3rgb_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (MAX_WIDTH)
  ) u_row_b (
    .clk_i   (clk_i),
    .we_i    (mv1),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_a_rdata),
    .re_i    (mv1),
    .raddr_i (s1_addr_q),
    .rdata_o (ram_b_rdata)
  );

  c3rgb_window u_window (
    .clk_i   (clk_i),
    .shift_i (mv2),
    .ctl_i   (s2_ctl_q),
    .bot_i   (s2_bot_q),
    .mid_i   (s2_mid_q),
    .top_i   (ram_b_rdata),
    .mode_i  (mode_q),
    .sum_o   (sum)
  );

  c3rgb_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (mv3 && sum.has_res),
    .sum_i       (sum),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ready_o     (post_ready)
  );

  // Assertions
  `C3RGB_ASSERT(a_addr_in_row, cfg_wait_q || (32'(a_q) < 32'(wc_q)), "row address past width")
  `C3RGB_ASSERT(a_count_bound, cfg_wait_q || (n_q <= size_w_q), "item count past frame end")
  `C3RGB_ASSERT_NEXT(a_frame_wrap, acc && s0_ctl.last, (n_q == '0) && (a_q == '0), "no frame wrap")

endmodule
